// ----- rtl/integer_text_formatter_defines.svh -----
// ----------------------------------------------------------------------------
// Integer text formatter assertion macros
// Shared concurrent assertion forms for the formatter's port checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TEXT_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ITF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ITF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itf_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter package
// Item types, format codes, controller states, commands and character tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itf_pkg;

  // Digit storage: 22 nibbles hold 20 BCD digits, 16 hex or 22 octal digits.
  localparam int NUM_DIGITS = 22;
  localparam int DIGITS_W   = 4 * NUM_DIGITS;
  localparam int VALUE_W    = 64;
  localparam int CONV_STEPS = 64;
  localparam int STEP_W     = 6;
  localparam int ND_W       = 5;
  localparam int NIL_LEN    = 5;
  localparam int NIL_W      = 3;

  // Format codes.
  localparam logic [2:0] FMT_DEC       = 3'd0;
  localparam logic [2:0] FMT_OCT       = 3'd1;
  localparam logic [2:0] FMT_HEX_LOWER = 3'd2;
  localparam logic [2:0] FMT_HEX_UPPER = 3'd3;
  localparam logic [2:0] FMT_POINTER   = 3'd4;

  // ASCII characters used by the formatter.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_A_UPPER = 8'h41;

  // One input item.
  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  format;
    logic [5:0]  field_width;
    logic [5:0]  min_digits;
    logic        is_negative;
    logic        force_plus;
    logic        alt_form;
    logic        left_justify;
    logic [2:0]  sink;
  } spec_t;

  // One result item.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [2:0] out_sink;
  } text_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_TRIM,
    ST_LAYOUT,
    ST_LEAD,
    ST_SIGN,
    ST_PREFIX,
    ST_ZEROS,
    ST_DIGITS,
    ST_TRAIL,
    ST_NIL
  } state_t;

  // Region of the text that the next character comes from.
  localparam int NUM_SRC = 7;
  typedef enum logic [2:0] {
    SRC_LEAD,
    SRC_SIGN,
    SRC_PREFIX,
    SRC_ZEROS,
    SRC_DIGITS,
    SRC_TRAIL,
    SRC_NIL
  } src_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic trim_step;
    logic layout;
    logic emit;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic               is_nil;
    logic               is_decimal;
    logic               conv_done;
    logic               trim_done;
    logic               room;
    logic [NUM_SRC-1:0] empty;
    logic [NUM_SRC-1:0] single;
  } sts_t;

  // ASCII for one digit nibble.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UPPER : CH_A_LOWER;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

  // Characters of the null pointer text, in order.
  function automatic logic [7:0] nil_char(input logic [NIL_W-1:0] idx);
    case (idx)
      3'd0:    nil_char = 8'h28;
      3'd1:    nil_char = 8'h6E;
      3'd2:    nil_char = 8'h69;
      3'd3:    nil_char = 8'h6C;
      3'd4:    nil_char = 8'h29;
      default: nil_char = CH_SPACE;
    endcase
  endfunction

endpackage

// ----- rtl/integer_text_formatter.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter
// Formats a 64-bit magnitude as decimal, octal, hex or pointer text and
// emits it one ASCII character per item.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   spec     in         spec_valid / spec_stall  spec_t (value and format spec)
//   text     out        text_valid / text_stall  text_t (character, last, sink)
//
// Each item passes through conversion, trimming, layout and the emitting states.
// Decimal runs 64 binary to BCD steps, one per cycle; other radixes load their
// digits directly. Trimming drops up to 21 leading zero digits, one per cycle.
// A null pointer goes from conversion straight to the five (nil) characters.
// Reset is synchronous and clears the controller and the output valid.
// A stall on text holds the output register and pauses emission; the next
// spec item is taken once the controller is back in idle.
`timescale 1ns / 1ps

module integer_text_formatter
  import itf_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = 48,
  parameter int MAX_PRECISION   = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  spec_valid,
  output logic  spec_stall,
  input  spec_t spec,
  output logic  text_valid,
  input  logic  text_stall,
  output text_t text
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  itf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .spec_valid (spec_valid),
    .spec_stall (spec_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Digit conversion and text generation.
  itf_dp #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
    .MAX_PRECISION   (MAX_PRECISION)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .spec       (spec),
    .cmd        (cmd),
    .sts        (sts),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule

// ----- rtl/itf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter controller
// Sequences conversion, digit trimming, layout and character emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itf_ctrl
  import itf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic spec_valid,
  output logic spec_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // Region decode for the emitting states.
  src_t   src;
  state_t follow;
  logic   emitting;
  logic   region_done;

  always_comb begin
    src      = SRC_LEAD;
    follow   = ST_IDLE;
    emitting = 1'b1;
    case (state)
      ST_LEAD: begin
        src    = SRC_LEAD;
        follow = ST_SIGN;
      end
      ST_SIGN: begin
        src    = SRC_SIGN;
        follow = ST_PREFIX;
      end
      ST_PREFIX: begin
        src    = SRC_PREFIX;
        follow = ST_ZEROS;
      end
      ST_ZEROS: begin
        src    = SRC_ZEROS;
        follow = ST_DIGITS;
      end
      ST_DIGITS: begin
        src    = SRC_DIGITS;
        follow = ST_TRAIL;
      end
      ST_TRAIL: begin
        src    = SRC_TRAIL;
        follow = ST_IDLE;
      end
      ST_NIL: begin
        src    = SRC_NIL;
        follow = ST_IDLE;
      end
      default: begin
        emitting = 1'b0;
      end
    endcase
    // A region ends when it is empty or its final character goes out now.
    region_done = sts.empty[src] || (sts.room && sts.single[src]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (spec_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts.is_nil) begin
          state_next = ST_NIL;
        end else if (!sts.is_decimal || sts.conv_done) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (sts.trim_done) state_next = ST_LAYOUT;
      end
      ST_LAYOUT: begin
        state_next = ST_LEAD;
      end
      ST_LEAD, ST_SIGN, ST_PREFIX, ST_ZEROS, ST_DIGITS, ST_TRAIL, ST_NIL: begin
        if (region_done) state_next = follow;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    spec_stall    = (state != ST_IDLE);
    cmd.load      = (state == ST_IDLE) && spec_valid;
    cmd.conv_step = (state == ST_CONVERT) && sts.is_decimal && !sts.is_nil;
    cmd.trim_step = (state == ST_TRIM) && !sts.trim_done;
    cmd.layout    = (state == ST_LAYOUT);
    cmd.emit      = emitting && !sts.empty[src] && sts.room;
    cmd.src       = src;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/itf_dp.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter datapath
// Holds the item, converts to digits, counts the text regions and drives the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itf_dp
  import itf_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = 48,
  parameter int MAX_PRECISION   = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  spec_t spec,
  input  cmd_t  cmd,
  output sts_t  sts,
  output logic  text_valid,
  input  logic  text_stall,
  output text_t text
);

  localparam int BODY_MAX = 3 + ((MAX_PRECISION > NUM_DIGITS) ? MAX_PRECISION : NUM_DIGITS);
  localparam int TEXT_MAX = (MAX_FIELD_WIDTH > BODY_MAX) ? MAX_FIELD_WIDTH : BODY_MAX;
  localparam int CW       = $clog2(TEXT_MAX + 1);
  localparam int PW       = $clog2(MAX_PRECISION + 1);

  // Item registers.
  logic [2:0]          fmt;
  logic                value_nz;
  logic                neg;
  logic                plus;
  logic                alt;
  logic                left;
  logic [2:0]          sink;
  logic [CW-1:0]       width;
  logic [PW-1:0]       prec;
  logic [VALUE_W-1:0]  value_sh;
  logic [DIGITS_W-1:0] digits;
  logic [STEP_W-1:0]   step_cnt;
  logic [ND_W-1:0]     nd;

  // Region counters.
  logic [CW-1:0]       lead_cnt;
  logic                sign_cnt;
  logic [1:0]          pre_cnt;
  logic [PW-1:0]       zero_cnt;
  logic [CW-1:0]       trail_cnt;
  logic [NIL_W-1:0]    nil_cnt;
  logic [CW-1:0]       remain;

  // Format decode.
  logic is_oct;
  logic is_hex;
  logic upper;
  logic [3:0] top_digit;

  always_comb begin
    is_oct    = (fmt == FMT_OCT);
    is_hex    = (fmt == FMT_HEX_LOWER) || (fmt == FMT_HEX_UPPER) || (fmt == FMT_POINTER);
    upper     = (fmt == FMT_HEX_UPPER);
    top_digit = digits[DIGITS_W-1 -: 4];
  end

  // Saturated width and precision of the incoming item.
  logic [CW-1:0] width_load;
  logic [PW-1:0] prec_load;

  always_comb begin
    if (int'(spec.field_width) > MAX_FIELD_WIDTH) begin
      width_load = CW'(MAX_FIELD_WIDTH);
    end else begin
      width_load = CW'(spec.field_width);
    end
    if (int'(spec.min_digits) > MAX_PRECISION) begin
      prec_load = PW'(MAX_PRECISION);
    end else begin
      prec_load = PW'(spec.min_digits);
    end
  end

  // Direct digit split for octal and hex; decimal starts from zero.
  logic [VALUE_W+1:0]  value_ext;
  logic [DIGITS_W-1:0] oct_digits;
  logic [DIGITS_W-1:0] hex_digits;
  logic [DIGITS_W-1:0] digits_load;

  always_comb begin
    value_ext  = {2'b00, spec.value};
    oct_digits = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      oct_digits[4*i +: 4] = {1'b0, value_ext[3*i +: 3]};
    end
    hex_digits = {{(DIGITS_W-VALUE_W){1'b0}}, spec.value};
    if (spec.format == FMT_OCT) begin
      digits_load = oct_digits;
    end else if ((spec.format == FMT_HEX_LOWER) || (spec.format == FMT_HEX_UPPER) ||
                 (spec.format == FMT_POINTER)) begin
      digits_load = hex_digits;
    end else begin
      digits_load = '0;
    end
  end

  // One shift-and-add-3 step of the binary to BCD conversion.
  logic [DIGITS_W-1:0] adj;
  logic [DIGITS_W-1:0] digits_conv;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits[4*i +: 4];
      end
    end
    digits_conv = {adj[DIGITS_W-2:0], value_sh[VALUE_W-1]};
  end

  // Text layout once the digit count is known.
  logic          sign_bit;
  logic [1:0]    plen;
  logic [CW-1:0] zeros_w;
  logic [CW-1:0] body;
  logic [CW-1:0] pad;

  always_comb begin
    sign_bit = neg || plus;
    if (CW'(prec) > CW'(nd)) begin
      zeros_w = CW'(prec) - CW'(nd);
    end else begin
      zeros_w = '0;
    end
    plen = 2'd0;
    if (alt && is_oct && (zeros_w == '0) && value_nz) begin
      plen = 2'd1;
    end else if (alt && is_hex && value_nz) begin
      plen = 2'd2;
    end
    body = CW'(sign_bit) + CW'(plen) + zeros_w + CW'(nd);
    if (width > body) begin
      pad = width - body;
    end else begin
      pad = '0;
    end
  end

  // Character of the selected region.
  logic [7:0] ch;

  always_comb begin
    case (cmd.src)
      SRC_LEAD, SRC_TRAIL: ch = CH_SPACE;
      SRC_SIGN:            ch = neg ? CH_MINUS : CH_PLUS;
      SRC_PREFIX: begin
        if ((pre_cnt == 2'd2) || is_oct) begin
          ch = CH_ZERO;
        end else begin
          ch = upper ? CH_X_UPPER : CH_X_LOWER;
        end
      end
      SRC_ZEROS:           ch = CH_ZERO;
      SRC_DIGITS:          ch = digit_char(top_digit, upper);
      SRC_NIL:             ch = nil_char(NIL_W'(NIL_LEN) - nil_cnt);
      default:             ch = CH_SPACE;
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts.is_nil     = (fmt == FMT_POINTER) && !value_nz;
    sts.is_decimal = !is_oct && !is_hex;
    sts.conv_done  = (step_cnt == STEP_W'(CONV_STEPS - 1));
    sts.trim_done  = (nd == ND_W'(1)) || (top_digit != 4'd0);
    sts.room       = !text_valid || !text_stall;

    sts.empty              = '0;
    sts.single             = '0;
    sts.empty[SRC_LEAD]    = (lead_cnt == '0);
    sts.single[SRC_LEAD]   = (lead_cnt == CW'(1));
    sts.empty[SRC_SIGN]    = !sign_cnt;
    sts.single[SRC_SIGN]   = sign_cnt;
    sts.empty[SRC_PREFIX]  = (pre_cnt == 2'd0);
    sts.single[SRC_PREFIX] = (pre_cnt == 2'd1);
    sts.empty[SRC_ZEROS]   = (zero_cnt == '0);
    sts.single[SRC_ZEROS]  = (zero_cnt == PW'(1));
    sts.empty[SRC_DIGITS]  = (nd == '0);
    sts.single[SRC_DIGITS] = (nd == ND_W'(1));
    sts.empty[SRC_TRAIL]   = (trail_cnt == '0);
    sts.single[SRC_TRAIL]  = (trail_cnt == CW'(1));
    sts.empty[SRC_NIL]     = (nil_cnt == '0);
    sts.single[SRC_NIL]    = (nil_cnt == NIL_W'(1));
  end

  // Item capture, conversion, trimming and region counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fmt      <= spec.format;
      value_nz <= (spec.value != '0);
      neg      <= spec.is_negative;
      plus     <= spec.force_plus;
      alt      <= spec.alt_form;
      left     <= spec.left_justify;
      sink     <= spec.sink;
      width    <= width_load;
      prec     <= prec_load;
      value_sh <= spec.value;
      digits   <= digits_load;
      step_cnt <= '0;
      nd       <= ND_W'(NUM_DIGITS);
      nil_cnt  <= NIL_W'(NIL_LEN);
      remain   <= CW'(NIL_LEN);
    end
    if (cmd.conv_step) begin
      digits   <= digits_conv;
      value_sh <= {value_sh[VALUE_W-2:0], 1'b0};
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (cmd.trim_step) begin
      digits <= {digits[DIGITS_W-5:0], 4'd0};
      nd     <= nd - ND_W'(1);
    end
    if (cmd.layout) begin
      lead_cnt  <= left ? '0 : pad;
      trail_cnt <= left ? pad : '0;
      sign_cnt  <= sign_bit;
      pre_cnt   <= plen;
      zero_cnt  <= PW'(zeros_w);
      remain    <= pad + body;
    end
    if (cmd.emit) begin
      remain <= remain - CW'(1);
      case (cmd.src)
        SRC_LEAD:   lead_cnt  <= lead_cnt - CW'(1);
        SRC_SIGN:   sign_cnt  <= 1'b0;
        SRC_PREFIX: pre_cnt   <= pre_cnt - 2'd1;
        SRC_ZEROS:  zero_cnt  <= zero_cnt - PW'(1);
        SRC_DIGITS: begin
          digits <= {digits[DIGITS_W-5:0], 4'd0};
          nd     <= nd - ND_W'(1);
        end
        SRC_TRAIL:  trail_cnt <= trail_cnt - CW'(1);
        SRC_NIL:    nil_cnt   <= nil_cnt - NIL_W'(1);
        default:    nil_cnt   <= nil_cnt;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.emit) begin
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text.character <= ch;
      text.last      <= (remain == CW'(1));
      text.out_sink  <= sink;
    end
  end

endmodule

// ----- rtl/itf_checker.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter port checker
// Watches the formatter's ports over time and reports broken behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_text_formatter_defines.svh"

module itf_checker
  import itf_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  spec_valid,
  input logic  spec_stall,
  input logic  text_valid,
  input logic  text_stall,
  input text_t text
);

  // An accepted spec item blocks the input in the following cycle.
  `ITF_ASSERT_NXT(a_busy_after_accept, clk, rst, spec_valid && !spec_stall, spec_stall, "input not blocked after an item was taken")

  // While a character that is not the last waits, the input stays blocked.
  `ITF_ASSERT_IMP(a_block_mid_text, clk, rst, text_valid && !text.last, spec_stall, "input open in the middle of a text")

  // Every character produced is printable ASCII.
  `ITF_ASSERT_IMP(a_printable, clk, rst, text_valid, (text.character >= 8'h20) && (text.character <= 8'h7E), "non-printable character")

  // A stalled output item holds.
  `ITF_ASSERT_NXT(a_hold_on_stall, clk, rst, text_valid && text_stall, text_valid && $stable(text), "output item changed under stall")

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
  .clk        (clk),
  .rst        (rst),
  .spec_valid (spec_valid),
  .spec_stall (spec_stall),
  .text_valid (text_valid),
  .text_stall (text_stall),
  .text       (text)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Integer text formatter testbench
// Drives format specs through the spec channel and checks every character on
// the text channel against table text or a behavioral formatter. Corner
// cases from a short table come first, then randomized specs, with bursty
// input and random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import itf_pkg::*;

  // Format codes outside the defined set; the block prints these as decimal.
  localparam logic [2:0] FMT_RESERVED_5 = 3'd5;
  localparam logic [2:0] FMT_RESERVED_6 = 3'd6;
  localparam logic [2:0] FMT_RESERVED_7 = 3'd7;

  localparam int FIELD_WIDTH_CAP = 48;
  localparam int PRECISION_CAP   = 32;
  localparam int RANDOM_ITEMS    = 420;
  localparam int TAIL_CYCLES     = 200;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // One row of the directed table; an empty string means use the formatter.
  typedef struct {
    spec_t spec;
    string text;
  } spec_row_t;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  spec_valid = 1'b0;
  logic  spec_stall;
  spec_t spec       = '0;
  logic  text_valid;
  logic  text_stall = 1'b0;
  text_t text;

  text_t       pending_text [$];
  spec_row_t   corner_rows [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int          stall_phase = 0;

  integer_text_formatter u_top (
    .clk        (clk),
    .rst        (rst),
    .spec_valid (spec_valid),
    .spec_stall (spec_stall),
    .spec       (spec),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic spec_t make_spec(input logic [63:0] value, input logic [2:0] fmt,
                                      input int width, input int prec, input bit neg,
                                      input bit plus, input bit alt, input bit left,
                                      input int sink);
    spec_t s;
    s.value        = value;
    s.format       = fmt;
    s.field_width  = 6'(width);
    s.min_digits   = 6'(prec);
    s.is_negative  = neg;
    s.force_plus   = plus;
    s.alt_form     = alt;
    s.left_justify = left;
    s.sink         = 3'(sink);
    return s;
  endfunction

  function automatic void add_row(input spec_t s, input string txt);
    spec_row_t row;
    row.spec = s;
    row.text = txt;
    corner_rows.push_back(row);
  endfunction

  // Turn a line of characters into the expected text items, last one marked.
  function automatic void queue_line(input logic [7:0] line [$], input logic [2:0] sink);
    text_t item;
    int    k;
    for (k = 0; k < line.size(); k++) begin
      item.character = line[k];
      item.last      = (k == line.size() - 1);
      item.out_sink  = sink;
      pending_text.push_back(item);
    end
  endfunction

  // Behavioral formatter: builds the full text of one spec.
  function automatic void format_text(input spec_t s);
    string      nil_text = "(nil)";
    logic [7:0] line [$];
    logic [7:0] rev [0:31];
    logic [7:0] hex_base;
    logic [63:0] x;
    bit         is_hex;
    bit         has_sign;
    int         w, prec, nd, zeros, plen, body, pad, k;

    w    = (s.field_width > FIELD_WIDTH_CAP) ? FIELD_WIDTH_CAP : s.field_width;
    prec = (s.min_digits > PRECISION_CAP) ? PRECISION_CAP : s.min_digits;

    // A null pointer prints a fixed word and ignores the rest of the spec.
    if (s.format == FMT_POINTER && s.value == '0) begin
      for (k = 0; k < nil_text.len(); k++) line.push_back(nil_text[k]);
      queue_line(line, s.sink);
      return;
    end

    is_hex   = (s.format == FMT_HEX_LOWER || s.format == FMT_HEX_UPPER ||
                s.format == FMT_POINTER);
    hex_base = (s.format == FMT_HEX_UPPER) ? CH_A_UPPER : CH_A_LOWER;

    // Digits, least significant first; zero still yields one digit.
    x  = s.value;
    nd = 0;
    do begin
      if (s.format == FMT_OCT) begin
        rev[nd] = CH_ZERO + 8'(x[2:0]);
        x = x >> 3;
      end else if (is_hex) begin
        rev[nd] = (x[3:0] < 4'd10) ? CH_ZERO + 8'(x[3:0]) : hex_base + 8'(x[3:0]) - 8'd10;
        x = x >> 4;
      end else begin
        rev[nd] = CH_ZERO + 8'(x % 10);
        x = x / 10;
      end
      nd++;
    end while (x != '0);

    zeros = (prec > nd) ? prec - nd : 0;

    // Octal prefix only when the text does not already start with a zero.
    plen = 0;
    if (s.alt_form) begin
      if (s.format == FMT_OCT) begin
        plen = (zeros == 0 && s.value != '0) ? 1 : 0;
      end else if (is_hex && s.value != '0) begin
        plen = 2;
      end
    end

    has_sign = s.is_negative || s.force_plus;
    body     = int'(has_sign) + plen + zeros + nd;
    pad      = (w > body) ? w - body : 0;

    if (!s.left_justify) begin
      for (k = 0; k < pad; k++) line.push_back(CH_SPACE);
    end
    if (has_sign) begin
      line.push_back(s.is_negative ? CH_MINUS : CH_PLUS);
    end
    if (plen > 0) begin
      line.push_back(CH_ZERO);
    end
    if (plen > 1) begin
      line.push_back((s.format == FMT_HEX_UPPER) ? CH_X_UPPER : CH_X_LOWER);
    end
    for (k = 0; k < zeros; k++) line.push_back(CH_ZERO);
    for (k = nd - 1; k >= 0; k--) line.push_back(rev[k]);
    if (s.left_justify) begin
      for (k = 0; k < pad; k++) line.push_back(CH_SPACE);
    end
    queue_line(line, s.sink);
  endfunction

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'($urandom_range(0, 999));
      2:       return {$urandom, $urandom};
      3:       return {$urandom, $urandom} >> $urandom_range(1, 63);
      4:       return ALL_ONES >> $urandom_range(0, 63);
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic spec_t random_spec();
    int         pick;
    logic [2:0] fmt;
    int         width, prec;
    pick  = $urandom_range(0, 11);
    fmt   = (pick < 10) ? 3'(pick % 5) : 3'(5 + $urandom_range(0, 2));
    width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
    prec  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
    return make_spec(random_value(), fmt, width, prec, $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 7));
  endfunction

  // Present one spec item and hold it until it is taken, then record its text.
  task automatic send_spec(input spec_t s, input string typed);
    logic [7:0] line [$];
    int         k;
    spec       <= s;
    spec_valid <= 1'b1;
    do @(posedge clk); while (spec_stall);
    if (typed.len() == 0) begin
      format_text(s);
    end else begin
      for (k = 0; k < typed.len(); k++) line.push_back(typed[k]);
      queue_line(line, s.sink);
    end
  endtask

  // Between items: keep the burst going, idle for a while, or drain fully.
  task automatic hold_off(input bit drain);
    int gap;
    if (!drain && burst_left > 0) begin
      burst_left--;
    end else begin
      spec_valid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (pending_text.size() != 0);
      end else begin
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    end
  endtask

  // Receiver stalls in randomly chosen modes, each kept for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 120);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:  text_stall <= 1'b0;
      STALL_LIGHT: text_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: text_stall <= ($urandom_range(0, 3) != 0);
      default:     text_stall <= (stall_phase % 5 < 2);
    endcase
  end

  // Check each accepted character against the oldest expected one.
  always @(posedge clk) begin : check_text
    text_t want;
    if (!rst && text_valid && !text_stall) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected text: expected none, got char %h last %b sink %0d",
                 $time, text.character, text.last, text.out_sink);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (text.character !== want.character) begin
          $display("%0t: character mismatch: expected %h, got %h",
                   $time, want.character, text.character);
          error_count++;
        end
        if (text.last !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, text.last);
          error_count++;
        end
        if (text.out_sink !== want.out_sink) begin
          $display("%0t: sink mismatch: expected %0d, got %0d",
                   $time, want.out_sink, text.out_sink);
          error_count++;
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_text_formatter test failed");
      $finish;
    end
  end

  initial begin
    int k;

    // Corner cases: extremes of each radix, prefixes, signs, padding and caps.
    add_row(make_spec('0, FMT_DEC, 0, 0, 0, 0, 0, 0, 0), "0");
    add_row(make_spec(ALL_ONES, FMT_DEC, 0, 0, 0, 0, 0, 0, 1), "18446744073709551615");
    add_row(make_spec(ALL_ONES, FMT_OCT, 0, 0, 0, 0, 0, 0, 2), "1777777777777777777777");
    add_row(make_spec(ALL_ONES, FMT_HEX_LOWER, 0, 0, 0, 0, 0, 0, 3), "ffffffffffffffff");
    add_row(make_spec(64'hDEAD_BEEF, FMT_HEX_UPPER, 0, 0, 0, 0, 1, 0, 4), "0XDEADBEEF");
    add_row(make_spec('0, FMT_POINTER, 20, 8, 1, 1, 1, 1, 5), "(nil)");
    add_row(make_spec(64'h1234, FMT_POINTER, 0, 0, 0, 0, 1, 0, 6), "0x1234");
    add_row(make_spec('0, FMT_HEX_LOWER, 0, 0, 0, 0, 1, 0, 7), "0");
    add_row(make_spec(64'd8, FMT_OCT, 0, 0, 0, 0, 1, 0, 0), "010");
    add_row(make_spec(64'd8, FMT_OCT, 0, 5, 0, 0, 1, 0, 1), "00010");
    add_row(make_spec('0, FMT_OCT, 0, 0, 0, 0, 1, 0, 2), "0");
    add_row(make_spec(64'd42, FMT_DEC, 0, 0, 0, 0, 1, 0, 3), "42");
    add_row(make_spec(64'd42, FMT_DEC, 0, 0, 1, 0, 0, 0, 4), "-42");
    add_row(make_spec(64'd42, FMT_DEC, 0, 0, 0, 1, 0, 0, 5), "+42");
    add_row(make_spec(64'd42, FMT_DEC, 0, 0, 1, 1, 0, 0, 6), "-42");
    add_row(make_spec(64'd255, FMT_HEX_LOWER, 0, 0, 1, 0, 1, 0, 7), "-0xff");
    add_row(make_spec(64'd42, FMT_DEC, 6, 0, 0, 0, 0, 0, 0), "    42");
    add_row(make_spec(64'd42, FMT_DEC, 6, 0, 0, 0, 0, 1, 1), "42    ");
    add_row(make_spec(64'd7, FMT_DEC, 6, 3, 0, 1, 0, 0, 2), "  +007");
    add_row(make_spec(64'd123, FMT_RESERVED_5, 0, 0, 0, 0, 1, 0, 3), "123");
    add_row(make_spec(ALL_ONES, FMT_RESERVED_6, 0, 0, 1, 0, 0, 0, 4), "");
    add_row(make_spec(64'd9, FMT_RESERVED_7, 63, 0, 0, 0, 0, 1, 5), "");
    add_row(make_spec(64'd1, FMT_HEX_LOWER, 0, 63, 0, 0, 1, 0, 6), "");
    add_row(make_spec(64'hABC, FMT_HEX_UPPER, 48, 32, 1, 0, 1, 0, 7), "");
    add_row(make_spec(ALL_ONES, FMT_POINTER, 48, 0, 0, 1, 1, 1, 5), "");

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table, then let everything drain before the random part.
    for (k = 0; k < corner_rows.size(); k++) begin
      send_spec(corner_rows[k].spec, corner_rows[k].text);
      hold_off(k == corner_rows.size() - 1);
    end

    // Random specs, with one full drain halfway and one at the end.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      send_spec(random_spec(), "");
      hold_off(k == RANDOM_ITEMS / 2 || k == RANDOM_ITEMS - 1);
    end

    // Watch for stray characters after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_text_formatter test passed");
    end else begin
      $display("integer_text_formatter test failed");
    end
    $finish;
  end

endmodule
